@@ rtl/dvt_pkg.sv @@
// Shared types, register codes and helpers of the detection vote tracker.
`timescale 1ns / 1ps

package dvt_pkg;

	localparam logic [9:0] VOTE_MAX = 10'd1023;

	typedef struct packed {
		logic [11:0] det_x;
		logic [11:0] det_y;
		logic [9:0]  det_radius;
		logic        last_in_frame;
	} det_t;

	typedef struct packed {
		logic        target_valid;
		logic [5:0]  target_label;
		logic [11:0] target_x;
		logic [11:0] target_y;
		logic [9:0]  target_radius;
		logic [9:0]  target_vote;
		logic        target_visible;
		logic        last_result;
	} res_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [9:0]  radius;
		logic [9:0]  vote;
	} cand_t;

	typedef struct packed {
		logic [5:0]  label;
		logic [11:0] x;
		logic [11:0] y;
		logic [9:0]  radius;
		logic [9:0]  vote;
		logic        visible;
	} tgt_t;

	typedef enum logic [2:0] {
		CFG_MATCH_TOL   = 3'd0,
		CFG_PROMOTE_TOL = 3'd1,
		CFG_TARGET_TOL  = 3'd2,
		CFG_PROMOTE_THR = 3'd3,
		CFG_HIT_INC     = 3'd4,
		CFG_NEW_VOTE    = 3'd5,
		CFG_REVOTE      = 3'd6,
		CFG_MISS_PEN    = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CAND_HOLD,
		CAND_VOTE,
		CAND_SHIFT
	} cand_op_t;

	typedef enum logic [2:0] {
		TGT_HOLD,
		TGT_CLEAR,
		TGT_CONFIRM,
		TGT_PENALTY,
		TGT_SHIFT
	} tgt_op_t;

	typedef struct packed {
		cand_op_t    op;
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  tol;
		logic [7:0]  inc;
	} cand_ctrl_t;

	typedef struct packed {
		tgt_op_t     op;
		logic [11:0] px;
		logic [11:0] py;
		logic [7:0]  tol;
		logic [7:0]  miss;
	} tgt_ctrl_t;

	function automatic logic in_tol(input logic [11:0] a, input logic [11:0] b,
		input logic [7:0] tol);
		logic [11:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d <= {4'd0, tol};
	endfunction

endpackage

@@ rtl/dvt_cand_cell.sv @@
// One candidate cell: holds one candidate, votes on a broadcast detection, shifts down.
`timescale 1ns / 1ps

module dvt_cand_cell import dvt_pkg::*; (
	input  logic       clk,
	input  cand_ctrl_t ctrl,
	input  logic       active,
	input  logic       load,
	input  cand_t      load_data,
	input  cand_t      next_data,
	output cand_t      data,
	output logic       hit
);

	cand_t       data_q;
	logic [10:0] sum;

	assign data = data_q;
	assign hit  = active && in_tol(ctrl.px, data_q.x, ctrl.tol)
		&& in_tol(ctrl.py, data_q.y, ctrl.tol);
	assign sum  = {1'b0, data_q.vote} + {3'd0, ctrl.inc};

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else if (ctrl.op == CAND_SHIFT) begin
			data_q <= next_data;
		end else if (ctrl.op == CAND_VOTE && hit) begin
			// Votes saturate at the top of the 10-bit range.
			data_q.vote <= sum[10] ? VOTE_MAX : sum[9:0];
		end
	end

endmodule

@@ rtl/dvt_tgt_cell.sv @@
// One target cell: holds one target, checks confirmations, applies the miss penalty.
`timescale 1ns / 1ps

module dvt_tgt_cell import dvt_pkg::*; (
	input  logic      clk,
	input  tgt_ctrl_t ctrl,
	input  logic      active,
	input  logic      load,
	input  tgt_t      load_data,
	input  tgt_t      next_data,
	output tgt_t      data,
	output logic      near
);

	tgt_t       data_q;
	logic       seen_q;
	logic [9:0] pen_vote;
	logic [9:0] fin_vote;

	assign data = data_q;
	assign near = active && in_tol(ctrl.px, data_q.x, ctrl.tol)
		&& in_tol(ctrl.py, data_q.y, ctrl.tol);

	assign pen_vote = (data_q.vote > {2'd0, ctrl.miss}) ? (data_q.vote - {2'd0, ctrl.miss})
		: 10'd0;
	assign fin_vote = seen_q ? data_q.vote : pen_vote;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end else begin
			case (ctrl.op)
				TGT_SHIFT: data_q <= next_data;
				TGT_PENALTY: begin
					if (active) begin
						data_q.vote    <= fin_vote;
						data_q.visible <= data_q.visible && (fin_vote != 10'd0);
					end
				end
				default: data_q <= data_q;
			endcase
		end
		case (ctrl.op)
			TGT_CLEAR:   seen_q <= 1'b0;
			TGT_CONFIRM: seen_q <= seen_q || near;
			default:     seen_q <= seen_q;
		endcase
	end

endmodule

@@ rtl/detection_vote_tracker.sv @@
// Top level of the detection vote tracker: control sequencer, frame store and cell rows.
`timescale 1ns / 1ps

// Detections enter on the det channel (det_valid / det_stall), one beat each; a frame
// ends with a beat that has last_in_frame set. Target reports leave on the res channel
// (res_valid / res_stall), one beat per target in table order, the final one marked by
// last_result; with no targets a single beat with target_valid low is sent.
// A detection that does not end its frame is broadcast to every candidate cell at once.
// The last detection of a frame starts the close sequence (a frame that seeded an empty
// candidate table goes straight to the report): the candidate row shifts through its
// head cell, one candidate per cycle, then the stored frame detections are read from
// the frame memory one per cycle, the S_PEN state applies the miss penalty, and the
// report rotates the target row, one beat per cycle while the receiver takes them.
// The candidate walk and the frame memory read port set the length of this sequence.
// det_stall is high during the whole close and report sequence; a detection may be
// taken while the final report beat still waits in the output register.
// When the receiver stalls, the output register holds its beat and the report waits.
// Reset empties the candidate and target tables, clears the frame count and label
// counter and loads the register defaults. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once and are meant for times when the block is idle.
module detection_vote_tracker import dvt_pkg::*; #(
	parameter int CAND_DEPTH   = 32,
	parameter int TARGET_DEPTH = 16,
	parameter int FRAME_DEPTH  = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       det_valid,
	output logic       det_stall,
	input  det_t       det,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);

	localparam int CCNT_W = $clog2(CAND_DEPTH + 1);
	localparam int TCNT_W = $clog2(TARGET_DEPTH + 1);
	localparam int FCNT_W = $clog2(FRAME_DEPTH + 1);
	localparam int FA_W   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_CLOSE  = 5'b00010,
		S_CONF   = 5'b00100,
		S_PEN    = 5'b01000,
		S_REPORT = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [7:0] match_tol_q, promote_tol_q, target_tol_q, hit_inc_q, new_vote_q, miss_pen_q;
	logic [9:0] promote_thr_q, revote_q;

	// Control state.
	logic [CCNT_W-1:0] ncand_q, pend_q, keep_q;
	logic [TCNT_W-1:0] tgt_cnt_q, rep_q;
	logic [FCNT_W-1:0] fdc_q, ra_q;
	logic [5:0]        label_q;
	logic              seeding_q;
	logic              rv_s1;
	logic              res_valid_q;
	res_t              res_q;

	// Frame detection store.
	logic [23:0] fmem [FRAME_DEPTH];
	logic [23:0] rdata_s1;
	logic        rd_en;

	// Cell rows.
	cand_ctrl_t              cand_ctrl;
	cand_t                   cand_d [CAND_DEPTH];
	logic [CAND_DEPTH-1:0]   cand_hit;
	logic                    cand_load_en;
	logic [CCNT_W-1:0]       cand_wr_idx;
	cand_t                   cand_wr_data;
	tgt_ctrl_t               tgt_ctrl;
	tgt_t                    tgt_d [TARGET_DEPTH];
	logic [TARGET_DEPTH-1:0] tgt_near;
	logic                    tgt_load_en;
	logic [TCNT_W-1:0]       tgt_wr_idx;
	tgt_t                    tgt_wr_data;

	logic  accept, seeding, any_hit, out_free, do_append;
	logic  promo, found, promote_new, survive;
	logic  rep_last;
	cand_t head;
	logic [9:0] keep_vote;

	assign det_stall = (state_q != S_IDLE);
	assign accept    = det_valid && !det_stall;
	assign seeding   = (fdc_q == '0) ? (ncand_q == '0) : seeding_q;
	assign any_hit   = |cand_hit;
	assign found     = |tgt_near;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign rd_en     = (state_q == S_CLOSE) ? 1'b0 : ((state_q == S_CONF) && (ra_q < fdc_q));
	assign rep_last  = (rep_q == tgt_cnt_q - TCNT_W'(1));
	assign do_append = (seeding || !any_hit) && (ncand_q < CCNT_W'(CAND_DEPTH));

	// The head cell of the candidate row is the one under evaluation at frame close.
	assign head        = cand_d[0];
	assign promo       = (head.vote != 10'd0) && ((head.vote - 10'd1) >= promote_thr_q);
	assign promote_new = promo && !found && (tgt_cnt_q < TCNT_W'(TARGET_DEPTH));
	assign keep_vote   = (promo && found) ? revote_q : (head.vote - 10'd1);
	assign survive     = (promo && found) ? (revote_q != 10'd0) : (head.vote > 10'd1);

	always_comb begin
		cand_ctrl     = '{op: CAND_HOLD, px: det.det_x, py: det.det_y, tol: match_tol_q,
			inc: hit_inc_q};
		cand_load_en  = 1'b0;
		cand_wr_idx   = ncand_q;
		cand_wr_data  = '{x: det.det_x, y: det.det_y, radius: det.det_radius,
			vote: seeding ? 10'd0 : {2'd0, new_vote_q}};
		tgt_ctrl      = '{op: TGT_HOLD, px: head.x, py: head.y, tol: promote_tol_q,
			miss: miss_pen_q};
		tgt_load_en   = 1'b0;
		tgt_wr_idx    = tgt_cnt_q;
		tgt_wr_data   = '{label: label_q, x: head.x, y: head.y, radius: head.radius,
			vote: head.vote - 10'd1, visible: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cand_ctrl.op = seeding ? CAND_HOLD : CAND_VOTE;
					cand_load_en = do_append;
				end
			end
			S_CLOSE: begin
				if (pend_q != '0) begin
					// Survivors re-enter behind the pending candidates, keeping table order.
					cand_ctrl.op  = CAND_SHIFT;
					cand_load_en  = survive;
					cand_wr_idx   = pend_q + keep_q - CCNT_W'(1);
					cand_wr_data  = '{x: head.x, y: head.y, radius: head.radius,
						vote: keep_vote};
					tgt_load_en   = promote_new;
				end else begin
					tgt_ctrl.op = TGT_CLEAR;
				end
			end
			S_CONF: begin
				tgt_ctrl.px  = rdata_s1[11:0];
				tgt_ctrl.py  = rdata_s1[23:12];
				tgt_ctrl.tol = target_tol_q;
				tgt_ctrl.op  = rv_s1 ? TGT_CONFIRM : TGT_HOLD;
			end
			S_PEN: begin
				tgt_ctrl.op = TGT_PENALTY;
			end
			S_REPORT: begin
				// The target row rotates once through its head cell during the report.
				if (out_free && tgt_cnt_q != '0) begin
					tgt_ctrl.op = TGT_SHIFT;
					tgt_load_en = 1'b1;
					tgt_wr_idx  = tgt_cnt_q - TCNT_W'(1);
					tgt_wr_data = tgt_d[0];
				end
			end
			default: begin
				cand_ctrl.op = CAND_HOLD;
			end
		endcase
	end

	for (genvar i = 0; i < CAND_DEPTH; i++) begin : g_cand
		cand_t nxt;
		if (i == CAND_DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cand_d[i+1];
		end
		dvt_cand_cell u_cell (
			.clk       (clk),
			.ctrl      (cand_ctrl),
			.active    (CCNT_W'(i) < ncand_q),
			.load      (cand_load_en && (cand_wr_idx == CCNT_W'(i))),
			.load_data (cand_wr_data),
			.next_data (nxt),
			.data      (cand_d[i]),
			.hit       (cand_hit[i])
		);
	end

	for (genvar j = 0; j < TARGET_DEPTH; j++) begin : g_tgt
		tgt_t nxt;
		if (j == TARGET_DEPTH - 1) begin : g_end
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = tgt_d[j+1];
		end
		dvt_tgt_cell u_cell (
			.clk       (clk),
			.ctrl      (tgt_ctrl),
			.active    (TCNT_W'(j) < tgt_cnt_q),
			.load      (tgt_load_en && (tgt_wr_idx == TCNT_W'(j))),
			.load_data (tgt_wr_data),
			.next_data (nxt),
			.data      (tgt_d[j]),
			.near      (tgt_near[j])
		);
	end

	// Frame store: written on each accepted detection while room is left, read in order
	// during confirmation.
	always_ff @(posedge clk) begin
		if (accept && fdc_q < FCNT_W'(FRAME_DEPTH)) begin
			fmem[fdc_q[FA_W-1:0]] <= {det.det_y, det.det_x};
		end
		if (rd_en) begin
			rdata_s1 <= fmem[ra_q[FA_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPORT && out_free) begin
			if (tgt_cnt_q == '0) begin
				res_q <= '{target_valid: 1'b0, target_label: 6'd0, target_x: 12'd0,
					target_y: 12'd0, target_radius: 10'd0, target_vote: 10'd0,
					target_visible: 1'b0, last_result: 1'b1};
			end else begin
				res_q <= '{target_valid: 1'b1, target_label: tgt_d[0].label,
					target_x: tgt_d[0].x, target_y: tgt_d[0].y,
					target_radius: tgt_d[0].radius, target_vote: tgt_d[0].vote,
					target_visible: tgt_d[0].visible, last_result: rep_last};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			match_tol_q   <= 8'd10;
			promote_tol_q <= 8'd10;
			target_tol_q  <= 8'd20;
			promote_thr_q <= 10'd30;
			hit_inc_q     <= 8'd3;
			new_vote_q    <= 8'd2;
			revote_q      <= 10'd32;
			miss_pen_q    <= 8'd5;
			ncand_q       <= '0;
			pend_q        <= '0;
			keep_q        <= '0;
			tgt_cnt_q     <= '0;
			rep_q         <= '0;
			fdc_q         <= '0;
			ra_q          <= '0;
			label_q       <= 6'd0;
			seeding_q     <= 1'b0;
			rv_s1         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MATCH_TOL:   match_tol_q   <= cfg_data[7:0];
					CFG_PROMOTE_TOL: promote_tol_q <= cfg_data[7:0];
					CFG_TARGET_TOL:  target_tol_q  <= cfg_data[7:0];
					CFG_PROMOTE_THR: promote_thr_q <= cfg_data;
					CFG_HIT_INC:     hit_inc_q     <= cfg_data[7:0];
					CFG_NEW_VOTE:    new_vote_q    <= cfg_data[7:0];
					CFG_REVOTE:      revote_q      <= cfg_data;
					CFG_MISS_PEN:    miss_pen_q    <= cfg_data[7:0];
					default:         miss_pen_q    <= miss_pen_q;
				endcase
			end

			rv_s1 <= rd_en;
			if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						seeding_q <= seeding;
						if (fdc_q < FCNT_W'(FRAME_DEPTH)) begin
							fdc_q <= fdc_q + FCNT_W'(1);
						end
						if (do_append) begin
							ncand_q <= ncand_q + CCNT_W'(1);
						end
						if (det.last_in_frame) begin
							if (seeding) begin
								rep_q   <= '0;
								fdc_q   <= '0;
								state_q <= S_REPORT;
							end else begin
								pend_q  <= ncand_q + CCNT_W'(do_append);
								keep_q  <= '0;
								state_q <= S_CLOSE;
							end
						end
					end
				end
				S_CLOSE: begin
					if (pend_q != '0) begin
						pend_q <= pend_q - CCNT_W'(1);
						if (survive) begin
							keep_q <= keep_q + CCNT_W'(1);
						end
						if (promote_new) begin
							tgt_cnt_q <= tgt_cnt_q + TCNT_W'(1);
							label_q   <= label_q + 6'd1;
						end
					end else begin
						ncand_q <= keep_q;
						ra_q    <= '0;
						state_q <= S_CONF;
					end
				end
				S_CONF: begin
					if (rd_en) begin
						ra_q <= ra_q + FCNT_W'(1);
					end else if (!rv_s1) begin
						state_q <= S_PEN;
					end
				end
				S_PEN: begin
					rep_q   <= '0;
					fdc_q   <= '0;
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						rep_q       <= rep_q + TCNT_W'(1);
						if (tgt_cnt_q == '0 || rep_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// An empty report is a single beat, so a beat without a target must close it.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.target_valid |-> res.last_result)
		else $error("target-less beat without last_result");

	a_cand_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ncand_q <= CCNT_W'(CAND_DEPTH) && pend_q + keep_q <= CCNT_W'(CAND_DEPTH))
		else $error("candidate count beyond table depth");

	a_tgt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_cnt_q <= TCNT_W'(TARGET_DEPTH))
		else $error("target count beyond table depth");

	// Labels advance only when a new target enters the table.
	a_label_step: assert property (@(posedge clk) disable iff (!arst_n)
		label_q != $past(label_q) |-> tgt_cnt_q == $past(tgt_cnt_q) + TCNT_W'(1))
		else $error("label advanced without promotion");
`endif

endmodule
